>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg - shared definitions for the complex arithmetic unit
// Operand format, operation and status codes, pipeline sideband type and
// the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	// quotient bits produced by the divider, one per stage
	localparam int QBITS      = DATA_WIDTH;
	// width of exact product sums and of their magnitudes
	localparam int PSUM_W     = 2 * DATA_WIDTH + 1;
	localparam int MAG_W      = 2 * DATA_WIDTH;
	localparam int WIDE_W     = PSUM_W + 1;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_SAT = 2'd1,
		STAT_DZ  = 2'd2,
		STAT_RSV = 2'd3
	} status_t;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	// what travels beside the divider lanes
	typedef struct packed {
		logic    vld;
		func_t   func;
		data_t   res_re;
		data_t   res_im;
		status_t status;
		logic    neg_re;
		logic    neg_im;
		logic    over_re;
		logic    over_im;
		logic    dz;
	} side_t;

	// saturate a wide signed value; returns {saturated, value}
	function automatic logic [DATA_WIDTH:0] sat_wide(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		begin
			hi = WIDE_W'(signed'({1'b0, {(DATA_WIDTH-1){1'b1}}}));
			lo = -hi - WIDE_W'(1);
			if (x > hi) begin
				sat_wide = {1'b1, 1'b0, {(DATA_WIDTH-1){1'b1}}};
			end else if (x < lo) begin
				sat_wide = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
			end else begin
				sat_wide = {1'b0, x[DATA_WIDTH-1:0]};
			end
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit - pipelined complex add, subtract, multiply, divide
// Signed Q8.8 operands, saturated results with a status code.
// ----------------------------------------------------------------------------
// Usage:
//   Drive func and the four operand parts with start high; the item is taken
//   at that clock edge when busy is low. busy is always low: a new item may
//   enter on every cycle.
//   Every item gives one result, shown for one cycle with done high on
//   res_re, res_im and status. Results leave in order.
//   Stages: one multiply stage, one product-sum stage, one scaling and
//   division set-up stage, sixteen divider stages (one quotient bit each)
//   and the output register. All operations take the same path length.
//   The block takes one item per cycle.
//   Reset clears the valid bits only; no result appears until an item is
//   taken. The receiver cannot stall the block, so nothing is held back.
//   Status: 0 ok, 1 a part saturated, 2 divide by zero (parts read zero).
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          func,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
	output logic                                     done,
	output logic signed [cau_pkg::DATA_WIDTH-1:0]    res_re,
	output logic signed [cau_pkg::DATA_WIDTH-1:0]    res_im,
	output logic [1:0]                               status
);

	localparam int DW  = cau_pkg::DATA_WIDTH;
	localparam int FB  = cau_pkg::FRAC_BITS;
	localparam int PW  = cau_pkg::PSUM_W;
	localparam int MW  = cau_pkg::MAG_W;
	localparam int XW  = cau_pkg::WIDE_W;
	localparam int QB  = cau_pkg::QBITS;

	// ---------------- stage 1: products and sums ----------------
	logic                  vld_s1;
	cau_pkg::func_t        func_s1;
	logic signed [DW:0]    sum_re_s1, sum_im_s1;
	logic signed [MW-1:0]  p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_r_s1, sq_i_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= cau_pkg::func_t'(func);
		if (cau_pkg::func_t'(func) == cau_pkg::FUNC_SUB) begin
			sum_re_s1 <= (DW+1)'(a_re) - (DW+1)'(b_re);
			sum_im_s1 <= (DW+1)'(a_im) - (DW+1)'(b_im);
		end else begin
			sum_re_s1 <= (DW+1)'(a_re) + (DW+1)'(b_re);
			sum_im_s1 <= (DW+1)'(a_im) + (DW+1)'(b_im);
		end
		p_rr_s1 <= MW'(a_re) * MW'(b_re);
		p_ii_s1 <= MW'(a_im) * MW'(b_im);
		p_ri_s1 <= MW'(a_re) * MW'(b_im);
		p_ir_s1 <= MW'(a_im) * MW'(b_re);
		sq_r_s1 <= MW'(b_re) * MW'(b_re);
		sq_i_s1 <= MW'(b_im) * MW'(b_im);
	end

	// ---------------- stage 2: product sums ----------------
	logic                  vld_s2;
	cau_pkg::func_t        func_s2;
	logic signed [DW:0]    sum_re_s2, sum_im_s2;
	logic signed [PW-1:0]  num_re_s2, num_im_s2;
	logic [MW-1:0]         den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2   <= func_s1;
		sum_re_s2 <= sum_re_s1;
		sum_im_s2 <= sum_im_s1;
		if (func_s1 == cau_pkg::FUNC_MUL) begin
			num_re_s2 <= PW'(p_rr_s1) - PW'(p_ii_s1);
			num_im_s2 <= PW'(p_ri_s1) + PW'(p_ir_s1);
		end else begin
			num_re_s2 <= PW'(p_rr_s1) + PW'(p_ii_s1);
			num_im_s2 <= PW'(p_ir_s1) - PW'(p_ri_s1);
		end
		den_s2 <= MW'(sq_r_s1) + MW'(sq_i_s1);
	end

	// ---------------- stage 3: scaling and divider set-up ----------------
	logic [DW:0]           sat_ar, sat_ai, sat_mr, sat_mi;
	logic signed [XW-1:0]  bias_re, bias_im, scl_re, scl_im;
	logic [PW-1:0]         abs_re, abs_im;
	logic [MW-1:0]         mag_re, mag_im;
	logic [MW+FB-1:0]      den_sh;
	cau_pkg::side_t        side_d;

	always_comb begin
		sat_ar = cau_pkg::sat_wide(XW'(sum_re_s2));
		sat_ai = cau_pkg::sat_wide(XW'(sum_im_s2));
		// truncate toward zero: bias negative values before the shift
		bias_re = XW'(num_re_s2) + (num_re_s2[PW-1] ? XW'((1 << FB) - 1) : XW'(0));
		bias_im = XW'(num_im_s2) + (num_im_s2[PW-1] ? XW'((1 << FB) - 1) : XW'(0));
		scl_re  = bias_re >>> FB;
		scl_im  = bias_im >>> FB;
		sat_mr  = cau_pkg::sat_wide(scl_re);
		sat_mi  = cau_pkg::sat_wide(scl_im);
		abs_re  = num_re_s2[PW-1] ? PW'(-num_re_s2) : PW'(num_re_s2);
		abs_im  = num_im_s2[PW-1] ? PW'(-num_im_s2) : PW'(num_im_s2);
		mag_re  = abs_re[MW-1:0];
		mag_im  = abs_im[MW-1:0];
		den_sh  = {den_s2, {FB{1'b0}}};

		side_d.vld     = vld_s2;
		side_d.func    = func_s2;
		side_d.neg_re  = num_re_s2[PW-1];
		side_d.neg_im  = num_im_s2[PW-1];
		// quotient of 2^DW or more always saturates
		side_d.over_re = {{FB{1'b0}}, mag_re} >= den_sh;
		side_d.over_im = {{FB{1'b0}}, mag_im} >= den_sh;
		side_d.dz      = (den_s2 == '0);
		case (func_s2)
			cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
				side_d.res_re = sat_ar[DW-1:0];
				side_d.res_im = sat_ai[DW-1:0];
				side_d.status = (sat_ar[DW] || sat_ai[DW]) ? cau_pkg::STAT_SAT
				                                           : cau_pkg::STAT_OK;
			end
			cau_pkg::FUNC_MUL: begin
				side_d.res_re = sat_mr[DW-1:0];
				side_d.res_im = sat_mi[DW-1:0];
				side_d.status = (sat_mr[DW] || sat_mi[DW]) ? cau_pkg::STAT_SAT
				                                           : cau_pkg::STAT_OK;
			end
			default: begin
				side_d.res_re = '0;
				side_d.res_im = '0;
				side_d.status = cau_pkg::STAT_OK;
			end
		endcase
	end

	cau_pkg::side_t   side_s3;
	logic [MW-1:0]    rem_re_s3, rem_im_s3, den_s3;
	logic [QB-1:0]    bits_re_s3, bits_im_s3;

	// advance the sideband; reset drops the valid bit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3.vld <= 1'b0;
		end else begin
			side_s3 <= side_d;
		end
	end

	always_ff @(posedge clk) begin
		// first remainder is the magnitude scaled down by 2^(QB-FB)
		rem_re_s3  <= MW'(mag_re >> (QB - FB));
		rem_im_s3  <= MW'(mag_im >> (QB - FB));
		bits_re_s3 <= QB'({mag_re, {FB{1'b0}}});
		bits_im_s3 <= QB'({mag_im, {FB{1'b0}}});
		den_s3     <= den_s2;
	end

	// ---------------- divider lanes ----------------
	logic [QB-1:0] quo_re, quo_im;

	cau_divider u_div_re (
		.clk  (clk),
		.rem  (rem_re_s3),
		.bits (bits_re_s3),
		.den  (den_s3),
		.quo  (quo_re)
	);

	cau_divider u_div_im (
		.clk  (clk),
		.rem  (rem_im_s3),
		.bits (bits_im_s3),
		.den  (den_s3),
		.quo  (quo_im)
	);

	// sideband delay matching the divider
	cau_pkg::side_t side_dl [QB+1];
	assign side_dl[0] = side_s3;

	for (genvar k = 0; k < QB; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_dl[k+1].vld <= 1'b0;
			end else begin
				side_dl[k+1] <= side_dl[k];
			end
		end
	end

	// ---------------- final selection ----------------
	cau_pkg::side_t side_f;
	logic           ng_re, ng_im, st_re, st_im;
	logic [DW-1:0]  q_re, q_im;
	logic [DW-1:0]  pos_max, neg_min;

	assign side_f = side_dl[QB];

	always_comb begin
		pos_max = {1'b0, {(DW-1){1'b1}}};
		neg_min = {1'b1, {(DW-1){1'b0}}};
		ng_re   = side_f.neg_re && (side_f.over_re || quo_re != '0);
		ng_im   = side_f.neg_im && (side_f.over_im || quo_im != '0);
		if (ng_re) begin
			st_re = side_f.over_re || (quo_re > neg_min);
			q_re  = st_re ? neg_min : DW'(~quo_re + 1'b1);
		end else begin
			st_re = side_f.over_re || (quo_re > pos_max);
			q_re  = st_re ? pos_max : quo_re;
		end
		if (ng_im) begin
			st_im = side_f.over_im || (quo_im > neg_min);
			q_im  = st_im ? neg_min : DW'(~quo_im + 1'b1);
		end else begin
			st_im = side_f.over_im || (quo_im > pos_max);
			q_im  = st_im ? pos_max : quo_im;
		end
	end

	logic                   done_q;
	logic signed [DW-1:0]   res_re_q, res_im_q;
	cau_pkg::status_t       status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_f.vld;
		end
	end

	// hold the finished item for its single output cycle
	always_ff @(posedge clk) begin
		if (side_f.func == cau_pkg::FUNC_DIV) begin
			if (side_f.dz) begin
				res_re_q <= '0;
				res_im_q <= '0;
				status_q <= cau_pkg::STAT_DZ;
			end else begin
				res_re_q <= q_re;
				res_im_q <= q_im;
				status_q <= (st_re || st_im) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
			end
		end else begin
			res_re_q <= side_f.res_re;
			res_im_q <= side_f.res_im;
			status_q <= side_f.status;
		end
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign status = status_q;

endmodule

`default_nettype wire

>>> rtl/core/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider - pipelined restoring divider lane
// One quotient bit per stage; when the starting remainder is below the divisor,
// the remainder always fits the divisor width.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_divider (
	input  wire logic                             clk,
	input  wire logic [cau_pkg::MAG_W-1:0]        rem,
	input  wire logic [cau_pkg::QBITS-1:0]        bits,
	input  wire logic [cau_pkg::MAG_W-1:0]        den,
	output logic      [cau_pkg::QBITS-1:0]        quo
);

	localparam int N = cau_pkg::QBITS;
	localparam int W = cau_pkg::MAG_W;

	logic [W-1:0] rem_s  [N+1];
	logic [N-1:0] bits_s [N+1];
	logic [W-1:0] den_s  [N+1];
	logic [N-1:0] quo_s  [N+1];

	assign rem_s[0]  = rem;
	assign bits_s[0] = bits;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;

	// one trial subtraction per stage
	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		assign trial = {rem_s[k], bits_s[k][N-1]};
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den_s[k]}) begin
				rem_s[k+1] <= diff[W-1:0];
				quo_s[k+1] <= {quo_s[k][N-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= trial[W-1:0];
				quo_s[k+1] <= {quo_s[k][N-2:0], 1'b0};
			end
			bits_s[k+1] <= {bits_s[k][N-2:0], 1'b0};
			den_s[k+1]  <= den_s[k];
		end
	end

	assign quo = quo_s[N];

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the complex arithmetic unit
// Drives operand pairs for add, subtract, multiply and divide through the
// start/busy handshake with random gaps, predicts each result in wide integer
// arithmetic and checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cau_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 1530;

	typedef struct {
		func_t func;
		data_t a_re;
		data_t a_im;
		data_t b_re;
		data_t b_im;
		int    gap;
	} cau_item_t;

	typedef struct {
		data_t   res_re;
		data_t   res_im;
		status_t status;
	} cau_result_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [1:0]  func   = '0;
	data_t       a_re   = '0;
	data_t       a_im   = '0;
	data_t       b_re   = '0;
	data_t       b_im   = '0;
	logic        busy;
	logic        done;
	data_t       res_re;
	data_t       res_im;
	logic [1:0]  status;

	cau_item_t   pending_items[$];
	cau_result_t expected_results[$];
	cau_item_t   held_item;
	int          gap_left   = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;

	complex_arithmetic_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.func   (func),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im),
		.done   (done),
		.res_re (res_re),
		.res_im (res_im),
		.status (status)
	);

	always #10 clk = ~clk;

	// clamp to the operand range, noting saturation
	function automatic data_t clamp_part(longint v, inout bit sat);
		longint hi;
		hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
		if (v > hi) begin
			sat = 1'b1;
			return data_t'(hi);
		end
		if (v < -hi - 1) begin
			sat = 1'b1;
			return data_t'(-hi - 1);
		end
		return data_t'(v);
	endfunction

	// exact complex arithmetic, truncated toward zero, then saturated
	function automatic cau_result_t predict_result(cau_item_t it);
		longint ar, ai, br, bi, re, im, den, scale;
		bit sat;
		cau_result_t r;
		ar = it.a_re;
		ai = it.a_im;
		br = it.b_re;
		bi = it.b_im;
		scale = longint'(1) << FRAC_BITS;
		sat = 1'b0;
		case (it.func)
			FUNC_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			FUNC_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			FUNC_MUL: begin
				re = (ar * br - ai * bi) / scale;
				im = (ar * bi + ai * br) / scale;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.res_re = '0;
					r.res_im = '0;
					r.status = STAT_DZ;
					return r;
				end
				re = ((ar * br + ai * bi) * scale) / den;
				im = ((ai * br - ar * bi) * scale) / den;
			end
		endcase
		r.res_re = clamp_part(re, sat);
		r.res_im = clamp_part(im, sat);
		r.status = sat ? STAT_SAT : STAT_OK;
		return r;
	endfunction

	// operand part: full range, extremes or small values
	function automatic data_t random_part();
		case ($urandom_range(0, 5))
			0:       return data_t'(-32768);
			1:       return data_t'(32767);
			2:       return data_t'($urandom_range(0, 8)) - data_t'(4);
			3:       return data_t'($urandom_range(0, 2047)) - data_t'(1024);
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic queue_item(func_t f, data_t ar, data_t ai, data_t br, data_t bi,
			int gap);
		cau_item_t it;
		it.func = f;
		it.a_re = ar;
		it.a_im = ai;
		it.b_re = br;
		it.b_im = bi;
		it.gap  = gap;
		pending_items.push_back(it);
	endtask

	// present items, honour each item's gap, hold while busy
	always @(posedge clk) begin
		cau_item_t nxt;
		logic      nstart;
		nstart = start;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_result(held_item));
				nstart = 1'b0;
			end
			if (!nstart) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					held_item = nxt;
					gap_left = nxt.gap;
					func <= nxt.func;
					a_re <= nxt.a_re;
					a_im <= nxt.a_im;
					b_re <= nxt.b_re;
					b_im <= nxt.b_im;
					nstart = 1'b1;
				end
			end
		end
		start <= nstart;
	end

	// compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		cau_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result re=%0d im=%0d status=%0d",
						res_re, res_im, status);
			end else begin
				want = expected_results.pop_front();
				if (res_re !== want.res_re || res_im !== want.res_im ||
						status !== want.status) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: expected re=%0d im=%0d status=%0d, got re=%0d im=%0d status=%0d",
							want.res_re, want.res_im, want.status,
							res_re, res_im, status);
				end
			end
		end
	end

	// stop a hung run: count cycles with no item taken and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("complex_arithmetic_unit test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int   burst;
		int   gap;
		func_t f;
		data_t br, bi;
		// directed: extremes, every operation, divide by zero, saturation
		for (int k = 0; k < 4; k++) begin
			f = func_t'(k);
			queue_item(f, -32768, -32768, -32768, -32768, 0);
			queue_item(f, 32767, 32767, 32767, 32767, 1);
			queue_item(f, 32767, -32768, -32768, 32767, 0);
			queue_item(f, 256, -512, 384, 128, 2);
		end
		queue_item(FUNC_DIV, 1000, -700, 0, 0, 0);
		queue_item(FUNC_DIV, 0, 0, 0, 0, 0);
		queue_item(FUNC_DIV, -32768, 32767, 1, 0, 0);
		queue_item(FUNC_DIV, 32767, 0, 0, -1, 3);
		queue_item(FUNC_DIV, -300, 77, -32768, 0, 0);
		queue_item(FUNC_MUL, 0, 0, -32768, 32767, 0);
		queue_item(FUNC_ADD, -1, -1, 1, 1, 6);
		queue_item(FUNC_SUB, -32768, 32767, 1, -1, 0);

		// random: runs of back-to-back items between runs with gaps
		burst = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 6);
			f = func_t'($urandom_range(0, 3));
			br = random_part();
			bi = random_part();
			if (f == FUNC_DIV && $urandom_range(0, 15) == 0) begin
				br = '0;
				bi = '0;
			end
			queue_item(f, random_part(), random_part(), br, bi, gap);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain, then allow for the pipeline latency
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("complex_arithmetic_unit test passed");
		else
			$display("complex_arithmetic_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire
